// ===== design/dual_fifo_strict_priority_queue_assert.svh =====
// Assertion macros for the dual FIFO strict priority queue.
`ifndef DUAL_FIFO_STRICT_PRIORITY_QUEUE_ASSERT_SVH
`define DUAL_FIFO_STRICT_PRIORITY_QUEUE_ASSERT_SVH

// Property that holds at every clock edge outside reset.
`define DFSPQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dfspq assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define DFSPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dfspq assertion failed");

`endif

// ===== design/dfspq_pkg.sv =====
// Types and constants shared by the dual FIFO strict priority queue.
package dfspq_pkg;

    localparam logic       CMD_ENQUEUE = 1'b0;
    localparam logic       CMD_SERVE   = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [15:0] client;
        logic [15:0] purchase;
    } entry_t;

    typedef struct packed {
        logic        cmd;
        logic        to_priority;
        logic [15:0] client_id;
        logic [15:0] purchase_id;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] served_client;
        logic [15:0] served_purchase;
        logic        from_priority;
        logic        end_marker;
        logic [3:0]  normal_count;
        logic [3:0]  priority_count;
    } rsp_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_sts_t;

endpackage

// ===== design/dual_fifo_strict_priority_queue.sv =====
// Top level of the dual FIFO strict priority queue.
//
// Usage: requests arrive on the req channel (req_valid/req_ready, payload req).
// cmd = enqueue writes {client_id, purchase_id} into the normal or priority
// FIFO as to_priority selects; a full FIFO rejects with status full.
// cmd = serve pops the oldest priority entry, or the oldest normal entry when
// the priority FIFO is empty; with both empty it answers status empty.
// Every transfer on req yields exactly one transfer on rsp, carrying the
// status, the served entry, its origin, an end flag for an all-zero entry and
// both fill levels after the item.
// Latency: the response is valid the cycle after the request transfer.
// Throughput: one item per cycle unless a held response stalls req; each FIFO
// is a row of cells where a push writes one cell and a pop shifts the whole
// row toward the head.
// Reset: both FIFOs come up empty and no response is pending; cell contents
// are left unreset and are never observed before being written.
// Stall: the response register holds while rsp_ready is low; req_ready drops
// until the response is taken, and rises again in the cycle it is taken.
module dual_fifo_strict_priority_queue
    import dfspq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

`include "dual_fifo_strict_priority_queue_assert.svh"

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          accept;
    logic          is_serve;
    fifo_ctl_t     n_ctl;
    fifo_ctl_t     p_ctl;
    fifo_sts_t     n_sts;
    fifo_sts_t     p_sts;
    entry_t        n_head;
    entry_t        p_head;
    entry_t        in_entry;
    entry_t        served;
    logic [CW-1:0] n_fill_next;
    logic [CW-1:0] p_fill_next;

    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    // Output register frees up in the same cycle it is drained.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign is_serve  = (req.cmd == CMD_SERVE);

    assign in_entry.client   = req.client_id;
    assign in_entry.purchase = req.purchase_id;

    // Strict priority: normal FIFO is served only when priority is empty.
    assign p_ctl.push = accept && !is_serve && req.to_priority && !p_sts.full;
    assign n_ctl.push = accept && !is_serve && !req.to_priority && !n_sts.full;
    assign p_ctl.pop  = accept && is_serve && !p_sts.empty;
    assign n_ctl.pop  = accept && is_serve && p_sts.empty && !n_sts.empty;

    dfspq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_normal (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (n_ctl),
        .din       (in_entry),
        .head      (n_head),
        .sts       (n_sts),
        .fill_next (n_fill_next)
    );

    dfspq_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_priority (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (p_ctl),
        .din       (in_entry),
        .head      (p_head),
        .sts       (p_sts),
        .fill_next (p_fill_next)
    );

    // Build the response for the item being accepted.
    always_comb
    begin
        served = p_ctl.pop ? p_head : n_head;

        rsp_next                 = '0;
        rsp_next.normal_count    = 4'(n_fill_next);
        rsp_next.priority_count  = 4'(p_fill_next);

        if (is_serve)
        begin
            if (p_ctl.pop || n_ctl.pop)
            begin
                rsp_next.status          = ST_DONE;
                rsp_next.served_client   = served.client;
                rsp_next.served_purchase = served.purchase;
                rsp_next.from_priority   = p_ctl.pop;
                rsp_next.end_marker      = (served == '0);
            end
            else
            begin
                rsp_next.status = ST_EMPTY;
            end
        end
        else
        begin
            rsp_next.status = (p_ctl.push || n_ctl.push) ? ST_DONE : ST_FULL;
        end
    end

    always_comb
    begin
        priority if (accept)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    // Payload register: loaded only on a request transfer.
    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `DFSPQ_ASSERT_NEXT(a_rsp_follows_req, accept, rsp_valid_reg)
    `DFSPQ_ASSERT(a_stall_only_when_held, req_ready || rsp_valid_reg)
    `DFSPQ_ASSERT_NEXT(a_priority_first, p_ctl.pop, rsp_reg.from_priority)
    `DFSPQ_ASSERT(a_end_only_when_done,
        !(rsp_valid_reg && rsp_reg.end_marker) || (rsp_reg.status == ST_DONE))
    `DFSPQ_ASSERT(a_single_pop, !(p_ctl.pop && n_ctl.pop))

endmodule

// ===== design/dfspq_cell.sv =====
// One storage cell of the shifting FIFO chain.
module dfspq_cell
    import dfspq_pkg::*;
(
    input  logic   clk,
    input  logic   load,
    input  logic   shift,
    input  entry_t din,
    input  entry_t upstream,
    output entry_t data
);

    entry_t data_reg;
    entry_t data_next;

    // Load and shift never coincide: one item either pushes or pops.
    always_comb
    begin
        priority if (load)
            data_next = din;
        else if (shift)
            data_next = upstream;
        else
            data_next = data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== design/dfspq_fifo.sv =====
// Shift FIFO built from a row of cells; head sits in cell 0.
module dfspq_fifo
    import dfspq_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  fifo_ctl_t                  ctl,
    input  entry_t                     din,
    output entry_t                     head,
    output fifo_sts_t                  sts,
    output logic [$clog2(DEPTH+1)-1:0] fill_next
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] fill_reg;
    entry_t        cell_data [DEPTH];
    entry_t        cell_up   [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == DEPTH - 1)
        begin : g_tail
            assign cell_up[i] = cell_data[i];
        end
        else
        begin : g_mid
            assign cell_up[i] = cell_data[i+1];
        end

        dfspq_cell u_cell (
            .clk      (clk),
            .load     (ctl.push && (fill_reg == CW'(i))),
            .shift    (ctl.pop),
            .din      (din),
            .upstream (cell_up[i]),
            .data     (cell_data[i])
        );
    end

    assign head      = cell_data[0];
    assign sts.empty = (fill_reg == '0);
    assign sts.full  = (fill_reg == CW'(DEPTH));

    always_comb
    begin
        priority if (ctl.push)
            fill_next = fill_reg + CW'(1);
        else if (ctl.pop)
            fill_next = fill_reg - CW'(1);
        else
            fill_next = fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

endmodule

// ===== tb/tb_dual_fifo_strict_priority_queue.sv =====
// Self-checking testbench for the dual FIFO strict priority queue.
module tb_dual_fifo_strict_priority_queue;
    import dfspq_pkg::*;

    localparam int DEPTH        = 8;
    localparam int N_ROWS       = 25;
    localparam int RANDOM_ITEMS = 1500;
    localparam int BLOCK_ITEMS  = 100;     // random items per traffic mix
    localparam int CALM_FROM    = 1300;    // no idling on either side from here on
    localparam int LONG_HOLD    = 60;      // receiver hold-off, in cycles
    localparam int CYCLE_LIMIT  = 200000;

    // One line of the directed table. Rows with fixed set carry a hand-typed
    // response; all others are checked against the queue model.
    typedef struct {
        req_t item;
        bit   fixed;
        rsp_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // Model state: contents of both FIFOs, oldest entry first.
    entry_t normal_model[$];
    entry_t prio_model[$];
    // Responses still owed by the block, oldest first.
    rsp_t   pending_rsp[$];

    row_t rows[N_ROWS];

    int errors  = 0;
    int n_items = 0;
    int n_full  = 0;
    int n_empty = 0;
    int n_prio  = 0;
    int n_end   = 0;
    int cycles  = 0;
    bit calm = 1'b0;            // set for the last stretch: no idling at all
    bit hold_request = 1'b0;    // sender asks the receiver for a long hold-off

    dual_fifo_strict_priority_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always #1 clk = ~clk;

    // Queue model: applies one request to the FIFO contents and returns the
    // response the block must give for it.
    function automatic rsp_t queue_step(req_t r);
        rsp_t   o;
        entry_t e;
        o = '0;
        e = '0;
        if (r.cmd == CMD_ENQUEUE) begin
            e.client   = r.client_id;
            e.purchase = r.purchase_id;
            if (r.to_priority) begin
                if (prio_model.size() >= DEPTH)
                    o.status = ST_FULL;
                else
                    prio_model.push_back(e);
            end
            else begin
                if (normal_model.size() >= DEPTH)
                    o.status = ST_FULL;
                else
                    normal_model.push_back(e);
            end
        end
        else if (prio_model.size() != 0) begin
            // strict priority: the priority FIFO always wins when non-empty
            e = prio_model.pop_front();
            o.from_priority = 1'b1;
        end
        else if (normal_model.size() != 0) begin
            e = normal_model.pop_front();
        end
        else begin
            o.status = ST_EMPTY;
        end
        // served fields stay zero for enqueues and empty serves
        if (r.cmd == CMD_SERVE && o.status == ST_DONE) begin
            o.served_client   = e.client;
            o.served_purchase = e.purchase;
            o.end_marker      = (e.client == 16'h0 && e.purchase == 16'h0);
        end
        o.normal_count   = 4'(normal_model.size());
        o.priority_count = 4'(prio_model.size());
        return o;
    endfunction

    function automatic req_t enq(bit to_prio, logic [15:0] client, logic [15:0] purchase);
        req_t r;
        r.cmd         = CMD_ENQUEUE;
        r.to_priority = to_prio;
        r.client_id   = client;
        r.purchase_id = purchase;
        return r;
    endfunction

    // Serve requests carry junk in the enqueue-only fields on purpose.
    function automatic req_t srv();
        req_t r;
        r.cmd         = CMD_SERVE;
        r.to_priority = 1'($urandom_range(0, 1));
        r.client_id   = 16'($urandom);
        r.purchase_id = 16'($urandom);
        return r;
    endfunction

    function automatic rsp_t status_only(logic [1:0] st, int nc, int pc);
        rsp_t o;
        o = '0;
        o.status         = st;
        o.normal_count   = 4'(nc);
        o.priority_count = 4'(pc);
        return o;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Offers one request, optionally after an idle burst, and holds it until
    // the transfer happens. Returns at the edge of the transfer, so the next
    // call can keep valid high without a gap.
    task automatic send_item(req_t r, bit fixed, rsp_t want, int idle_pct);
        rsp_t exp_rsp;
        int   gap;
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        // model always advances; typed rows override only the expectation
        exp_rsp = queue_step(r);
        if (fixed)
            exp_rsp = want;
        pending_rsp.push_back(exp_rsp);
        n_items++;
        if (exp_rsp.status == ST_FULL)  n_full++;
        if (exp_rsp.status == ST_EMPTY) n_empty++;
        if (exp_rsp.from_priority)      n_prio++;
        if (exp_rsp.end_marker)         n_end++;
    endtask

    // Response side: each transfer is checked against the oldest expectation.
    always @(posedge clk) begin
        rsp_t exp_rsp;
        if (rst_n && rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response: expected none, got %p", $time, rsp);
                errors++;
            end
            else begin
                exp_rsp = pending_rsp.pop_front();
                check_field("status",          16'(exp_rsp.status),          16'(rsp.status));
                check_field("served_client",   exp_rsp.served_client,        rsp.served_client);
                check_field("served_purchase", exp_rsp.served_purchase,      rsp.served_purchase);
                check_field("from_priority",   16'(exp_rsp.from_priority),   16'(rsp.from_priority));
                check_field("end_marker",      16'(exp_rsp.end_marker),      16'(rsp.end_marker));
                check_field("normal_count",    16'(exp_rsp.normal_count),    16'(rsp.normal_count));
                check_field("priority_count",  16'(exp_rsp.priority_count),  16'(rsp.priority_count));
            end
        end
    end

    // Receiver: random stall bursts at a rate that is redrawn during the run
    // (sometimes zero), plus a long hold-off on request so the response register
    // backs up and req_ready drops.
    initial begin
        int stall_left;
        int stall_pct;
        int epoch;
        stall_left = 0;
        stall_pct  = 10;
        epoch      = 0;
        rsp_ready  = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            epoch++;
            if (epoch % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    default: stall_pct = 30;
                endcase
            end
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 7);
                rsp_ready <= 1'b0;
            end
            else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // Watchdog: far above the slowest legal run.
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d responses outstanding", $time, pending_rsp.size());
            $display("tb_dual_fifo_strict_priority_queue: done, errors");
            $finish;
        end
    end

    initial begin
        int   enq_pct;
        int   prio_pct;
        int   idle_pct;
        req_t r;

        enq_pct   = 50;
        prio_pct  = 50;
        idle_pct  = 0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;

        // Directed table. Walk: serve on empty, fill normal to the brim with
        // extreme and checkerboard patterns, overflow it, check that priority
        // entries are served first, end markers from both FIFOs, then fill
        // and overflow the priority FIFO. The random part drains it later.
        rows[0]  = row_t'{srv(), 1'b1, status_only(ST_EMPTY, 0, 0)};
        rows[1]  = row_t'{enq(1'b0, 16'h0000, 16'h0000), 1'b0, '0};
        rows[2]  = row_t'{enq(1'b0, 16'hffff, 16'hffff), 1'b0, '0};
        rows[3]  = row_t'{enq(1'b0, 16'h5555, 16'haaaa), 1'b0, '0};
        rows[4]  = row_t'{enq(1'b0, 16'haaaa, 16'h5555), 1'b0, '0};
        rows[5]  = row_t'{enq(1'b1, 16'h8000, 16'h0001), 1'b0, '0};
        rows[6]  = row_t'{enq(1'b0, 16'h0001, 16'h8000), 1'b0, '0};
        rows[7]  = row_t'{enq(1'b0, 16'h7fff, 16'hfffe), 1'b0, '0};
        rows[8]  = row_t'{enq(1'b0, 16'h0100, 16'h0010), 1'b0, '0};
        rows[9]  = row_t'{enq(1'b0, 16'h0002, 16'h0003), 1'b0, '0};
        rows[10] = row_t'{enq(1'b0, 16'h1234, 16'h5678), 1'b1, status_only(ST_FULL, 8, 1)};
        rows[11] = row_t'{enq(1'b1, 16'h0000, 16'h0000), 1'b0, '0};
        rows[12] = row_t'{srv(), 1'b0, '0};
        rows[13] = row_t'{srv(), 1'b0, '0};
        rows[14] = row_t'{srv(), 1'b0, '0};
        rows[15] = row_t'{srv(), 1'b0, '0};
        for (int i = 16; i < 24; i++)
            rows[i] = row_t'{enq(1'b1, 16'($urandom), 16'($urandom)), 1'b0, '0};
        rows[24] = row_t'{enq(1'b1, 16'hffff, 16'h0000), 1'b1, status_only(ST_FULL, 6, 8)};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_item(rows[i].item, rows[i].fixed, rows[i].want, 20);

        // Random traffic in blocks with their own mix: enqueue-heavy blocks
        // run the FIFOs into full, serve-heavy blocks drain them to empty.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % BLOCK_ITEMS == 0) begin
                case ($urandom_range(0, 3))
                    0:       enq_pct = 85;
                    1:       enq_pct = 15;
                    default: enq_pct = 50;
                endcase
                prio_pct = 20 + 30 * $urandom_range(0, 2);
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 30;
                endcase
            end
            if (k == CALM_FROM)
                calm = 1'b1;
            if (k == 300 || k == 900)
                hold_request = 1'b1;
            r.cmd         = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_SERVE;
            r.to_priority = ($urandom_range(0, 99) < prio_pct);
            case ($urandom_range(0, 15))
                0: begin
                    r.client_id   = 16'h0000;   // end marker when served
                    r.purchase_id = 16'h0000;
                end
                1: begin
                    r.client_id   = 16'hffff;
                    r.purchase_id = 16'hffff;
                end
                default: begin
                    r.client_id   = 16'($urandom);
                    r.purchase_id = 16'($urandom);
                end
            endcase
            send_item(r, 1'b0, '0, idle_pct);
        end
        req_valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);

        $display("%0d requests, %0d rejected as full, %0d serves on empty,", n_items, n_full,
                 n_empty);
        $display("%0d served from priority, %0d end markers seen", n_prio, n_end);
        if (errors == 0)
            $display("tb_dual_fifo_strict_priority_queue: done, clean");
        else
            $display("tb_dual_fifo_strict_priority_queue: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/dfspq_pkg.sv
design/dfspq_cell.sv
design/dfspq_fifo.sv
design/dual_fifo_strict_priority_queue.sv
tb/tb_dual_fifo_strict_priority_queue.sv
